// ===== hdl/cscan_disk_seek_order_unit_assert.svh =====
// Assertion macros shared by the C-SCAN seek order unit.
`ifndef CSCAN_DISK_SEEK_ORDER_UNIT_ASSERT_SVH
`define CSCAN_DISK_SEEK_ORDER_UNIT_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define CSCAN_ASSERT_HOLD(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication.
`define CSCAN_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CSCAN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/cscan_pkg.sv =====
// Shared constants and types for the C-SCAN seek order unit.
package cscan_pkg;

   localparam int CYL_BITS     = 16;
   localparam int MAX_REQUESTS = 16;
   localparam int IDX_BITS     = $clog2(MAX_REQUESTS);
   localparam int CNT_BITS     = $clog2(MAX_REQUESTS + 1);
   localparam int DIST_BITS    = 16;
   localparam int TOTAL_BITS   = 21;
   localparam int KEY_BITS     = CYL_BITS + IDX_BITS;

   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
   localparam logic [CNT_BITS-1:0]   CNT_MAX   = CNT_BITS'(MAX_REQUESTS);

   // CSR bus
   localparam int ADDR_BITS = 4;
   localparam int DATA_BITS = 32;

   // register index codes (paddr[3:2])
   localparam logic [1:0] REG_LOWER = 2'd0;
   localparam logic [1:0] REG_UPPER = 2'd1;
   localparam logic [1:0] REG_HEAD  = 2'd2;

   typedef struct packed {
      logic [CYL_BITS-1:0] lower;
      logic [CYL_BITS-1:0] upper;
      logic [CYL_BITS-1:0] head;
   } csr_regs_type;

   // one position handed from the sequencer to the output stage
   typedef struct packed {
      logic                valid;
      logic                first;
      logic                last;
      logic [CYL_BITS-1:0] cyl;
   } emit_req_type;

endpackage

// ===== hdl/cscan_ram.sv =====
// Generic single-port-write, registered-read RAM.
module cscan_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/cscan_csr.sv =====
// APB-style configuration registers: bounds and head position.
module cscan_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [cscan_pkg::ADDR_BITS-1:0] paddr,
   input  logic [cscan_pkg::DATA_BITS-1:0] pwdata,
   output logic [cscan_pkg::DATA_BITS-1:0] prdata,
   output logic                           pready,
   output cscan_pkg::csr_regs_type        regs
);
   import cscan_pkg::*;

   logic [CYL_BITS-1:0] lower_ff, lower_in;
   logic [CYL_BITS-1:0] upper_ff, upper_in;
   logic [CYL_BITS-1:0] head_ff, head_in;
   logic                wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      lower_in = lower_ff;
      upper_in = upper_ff;
      head_in  = head_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            REG_LOWER: lower_in = pwdata[CYL_BITS-1:0];
            REG_UPPER: upper_in = pwdata[CYL_BITS-1:0];
            REG_HEAD:  head_in  = pwdata[CYL_BITS-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= '0;
         upper_ff <= '1;
         head_ff  <= '0;
      end else begin
         lower_ff <= lower_in;
         upper_ff <= upper_in;
         head_ff  <= head_in;
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_LOWER: prdata = DATA_BITS'(lower_ff);
         REG_UPPER: prdata = DATA_BITS'(upper_ff);
         REG_HEAD:  prdata = DATA_BITS'(head_ff);
         default:   prdata = '0;
      endcase
   end

   assign regs.lower = lower_ff;
   assign regs.upper = upper_ff;
   assign regs.head  = head_ff;

endmodule

// ===== hdl/cscan_emit.sv =====
// Output stage: seek distance, running total and the result register.
module cscan_emit (
   input  logic                                clock,
   input  logic                                reset,
   input  cscan_pkg::emit_req_type             push,
   output logic                                ready,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cscan_pkg::CYL_BITS-1:0]      rsp_service_cylinder,
   output logic [cscan_pkg::DIST_BITS-1:0]     rsp_seek_distance,
   output logic [cscan_pkg::TOTAL_BITS-1:0]    rsp_total_seek,
   output logic                                rsp_last_result
);
   import cscan_pkg::*;

   logic                  valid_ff, valid_in;
   logic [CYL_BITS-1:0]   cyl_ff;
   logic [DIST_BITS-1:0]  dist_ff, dist_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic                  last_ff;
   logic [CYL_BITS-1:0]   diff;
   logic [TOTAL_BITS-1:0] base;
   logic [TOTAL_BITS:0]   sum;
   logic                  load;

   // register frees up when empty or when its result transfers this cycle
   assign ready = !valid_ff || !rsp_stall;
   assign load  = push.valid && ready;

   // previous position is the cylinder still sitting in the result register
   assign diff = (push.cyl >= cyl_ff) ? (push.cyl - cyl_ff) : (cyl_ff - push.cyl);

   always_comb begin
      dist_in = push.first ? '0 : DIST_BITS'(diff);
      base    = push.first ? '0 : total_ff;
      sum     = {1'b0, base} + (TOTAL_BITS + 1)'(dist_in);
      total_in = (sum > (TOTAL_BITS + 1)'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cyl_ff   <= push.cyl;
         dist_ff  <= dist_in;
         total_ff <= total_in;
         last_ff  <= push.last;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_service_cylinder = cyl_ff;
   assign rsp_seek_distance    = dist_ff;
   assign rsp_total_seek       = total_ff;
   assign rsp_last_result      = last_ff;

endmodule

// ===== hdl/cscan_seq.sv =====
// Batch loader and selection sequencer over the request RAM.
`include "cscan_disk_seek_order_unit_assert.svh"

module cscan_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cscan_pkg::CYL_BITS-1:0]    req_request_cylinder,
   input  logic                              req_last_request,
   input  cscan_pkg::csr_regs_type           regs,
   output cscan_pkg::emit_req_type           push,
   input  logic                              push_ready
);
   import cscan_pkg::*;

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_HEAD  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_PICK  = 3'd3;
   localparam logic [2:0] ST_UPPER = 3'd4;
   localparam logic [2:0] ST_LOWER = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] emitted_ff, emitted_in;
   logic [CNT_BITS-1:0] scan_ff, scan_in;
   logic                phase_ff, phase_in;     // 0: above head, 1: at or below
   logic [KEY_BITS-1:0] cur_ff, cur_in;
   logic                cur_valid_ff, cur_valid_in;
   logic [KEY_BITS-1:0] best_ff, best_in;
   logic                best_found_ff, best_found_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_BITS-1:0] rd_idx_ff, rd_idx_in;

   logic                req_acc;
   logic                push_acc;
   logic                issue;
   logic                ram_we;
   logic [CYL_BITS-1:0] rd_data;
   logic [KEY_BITS-1:0] key;
   logic                qualify;
   logic                better;
   logic                finish;

   // writes happen only while loading and reads only while scanning,
   // so the two RAM ports never touch the same entry in one cycle
   cscan_ram #(
      .WIDTH (CYL_BITS),
      .DEPTH (MAX_REQUESTS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[IDX_BITS-1:0]),
      .wdata (req_request_cylinder),
      .re    (issue),
      .raddr (scan_ff[IDX_BITS-1:0]),
      .rdata (rd_data)
   );

   assign req_stall = (state_ff != ST_LOAD);
   assign req_acc   = req_valid && !req_stall;
   assign push_acc  = push.valid && push_ready;
   assign issue     = (state_ff == ST_SCAN) && (scan_ff < count_ff);

   // entries ordered by (cylinder, slot) so duplicates keep a strict order
   assign key     = {rd_data, rd_idx_ff};
   assign qualify = (!cur_valid_ff || (key > cur_ff)) &&
                    (!phase_ff || (rd_data <= regs.head));
   assign better  = !best_found_ff || (key < best_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      emitted_in    = emitted_ff;
      scan_in       = scan_ff;
      phase_in      = phase_ff;
      cur_in        = cur_ff;
      cur_valid_in  = cur_valid_ff;
      best_in       = best_ff;
      best_found_in = best_found_ff;
      rd_vld_in     = issue;
      rd_idx_in     = scan_ff[IDX_BITS-1:0];
      ram_we        = 1'b0;
      finish        = 1'b0;
      push          = '0;

      if (issue) begin
         scan_in = scan_ff + 1'b1;
      end
      if (rd_vld_ff && qualify && better) begin
         best_in       = key;
         best_found_in = 1'b1;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               // a full store drops the request, a closing one still closes
               if (count_ff < CNT_MAX) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (req_last_request) begin
                  state_in = ST_HEAD;
               end
            end
         end
         ST_HEAD: begin
            push.valid = 1'b1;
            push.first = 1'b1;
            push.cyl   = regs.head;
            if (push_acc) begin
               phase_in      = 1'b0;
               cur_in        = {regs.head, {IDX_BITS{1'b1}}};
               cur_valid_in  = 1'b1;
               scan_in       = '0;
               best_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!issue && !rd_vld_ff) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (best_found_ff) begin
               push.valid = 1'b1;
               push.cyl   = best_ff[KEY_BITS-1:IDX_BITS];
               push.last  = phase_ff && (CNT_BITS'(emitted_ff + 1'b1) == count_ff);
               if (push_acc) begin
                  emitted_in    = emitted_ff + 1'b1;
                  cur_in        = best_ff;
                  cur_valid_in  = 1'b1;
                  scan_in       = '0;
                  best_found_in = 1'b0;
                  if (push.last) begin
                     finish = 1'b1;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end else if (!phase_ff) begin
               state_in = ST_UPPER;
            end else begin
               finish = 1'b1;
            end
         end
         ST_UPPER: begin
            push.valid = 1'b1;
            push.cyl   = regs.upper;
            if (push_acc) begin
               state_in = ST_LOWER;
            end
         end
         ST_LOWER: begin
            push.valid = 1'b1;
            push.cyl   = regs.lower;
            push.last  = (emitted_ff == count_ff);
            if (push_acc) begin
               if (push.last) begin
                  finish = 1'b1;
               end else begin
                  phase_in      = 1'b1;
                  cur_valid_in  = 1'b0;
                  scan_in       = '0;
                  best_found_in = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (finish) begin
         state_in   = ST_LOAD;
         count_in   = '0;
         emitted_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         emitted_ff    <= '0;
         scan_ff       <= '0;
         phase_ff      <= 1'b0;
         cur_valid_ff  <= 1'b0;
         best_found_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         emitted_ff    <= emitted_in;
         scan_ff       <= scan_in;
         phase_ff      <= phase_in;
         cur_valid_ff  <= cur_valid_in;
         best_found_ff <= best_found_in;
         rd_vld_ff     <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      best_ff   <= best_in;
      rd_idx_ff <= rd_idx_in;
   end

   `CSCAN_ASSERT_HOLD(a_count_in_range, count_ff <= CNT_MAX, "request count overflow")
   `CSCAN_ASSERT_HOLD(a_emitted_le_count, emitted_ff <= count_ff, "emitted more than stored")
   `CSCAN_ASSERT_IMP(a_write_only_loading, ram_we, state_ff == ST_LOAD, "store write while busy")
   `CSCAN_ASSERT_NEXT(a_last_ends_batch, push_acc && push.last, state_ff == ST_LOAD && count_ff == '0, "batch not closed after last result")

endmodule

// ===== hdl/cscan_disk_seek_order_unit.sv =====
// C-SCAN disk seek order unit: request loading, ordering and result emission.
//
// Requests transfer on the req_ channel one per cycle into a 16-entry RAM.
// A request with req_last_request set closes the batch: the block then
// stalls its input and emits the C-SCAN service run on the rsp_ channel:
// the head, requests above it ascending, upper bound, lower bound, then the
// requests at or below the head ascending (n requests give n+3 results).
// Each result carries the seek distance and running total; the final one
// has rsp_last_result set. Requests beyond 16 are dropped.
// Ordering uses selection passes: the sequencer reads the RAM one
// entry per cycle to find the next larger (cylinder, slot) key. The head
// result passes through the head state and the result register after the
// closing transfer. The single RAM read port sets the pace of each pass.
// rsp_stall holds the result register and pauses the sequencer; no result
// is lost. Reset (synchronous) empties the batch and loads lower bound 0,
// upper bound 65535 and head 0. The user writes registers at 0x0/0x4/0x8
// only while no batch is being emitted; the block does not enforce this.
// The head is sampled during emission.
module cscan_disk_seek_order_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cscan_pkg::CYL_BITS-1:0]      req_request_cylinder,
   input  logic                                req_last_request,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cscan_pkg::CYL_BITS-1:0]      rsp_service_cylinder,
   output logic [cscan_pkg::DIST_BITS-1:0]     rsp_seek_distance,
   output logic [cscan_pkg::TOTAL_BITS-1:0]    rsp_total_seek,
   output logic                                rsp_last_result,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cscan_pkg::ADDR_BITS-1:0]     paddr,
   input  logic [cscan_pkg::DATA_BITS-1:0]     pwdata,
   output logic [cscan_pkg::DATA_BITS-1:0]     prdata,
   output logic                                pready
);
   import cscan_pkg::*;

   csr_regs_type regs;
   emit_req_type push;
   logic         push_ready;

   // bounds and head registers
   cscan_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .regs    (regs)
   );

   // loads the batch, then walks the RAM in selection passes
   cscan_seq u_seq (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_request_cylinder (req_request_cylinder),
      .req_last_request     (req_last_request),
      .regs                 (regs),
      .push                 (push),
      .push_ready           (push_ready)
   );

   // distance/total math and the result register that decouples rsp_stall
   cscan_emit u_emit (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .ready                (push_ready),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_service_cylinder (rsp_service_cylinder),
      .rsp_seek_distance    (rsp_seek_distance),
      .rsp_total_seek       (rsp_total_seek),
      .rsp_last_result      (rsp_last_result)
   );

endmodule
